/* sv/lewh_pkg.sv */
package lewh_pkg;
    localparam int LineBytesDef = 64;
    localparam int HistEntriesDef = 16;
    localparam int MaxResults = 64;

    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_REDRAW = 2'd1,
        ACT_READY  = 2'd2,
        ACT_COMMIT = 2'd3
    } t_action;

    localparam logic [7:0] ChEsc  = 8'h1b;
    localparam logic [7:0] ChDel  = 8'h7f;
    localparam logic [7:0] ChBs   = 8'h08;
    localparam logic [7:0] ChNak  = 8'h15;
    localparam logic [7:0] ChSp   = 8'h20;
    localparam logic [7:0] ChLbr  = 8'h5b;
    localparam logic [7:0] ChUp   = 8'h41;
    localparam logic [7:0] ChDn   = 8'h42;
    localparam logic [7:0] ChCr   = 8'h0d;
    localparam logic [7:0] ChLf   = 8'h0a;

    typedef struct packed {
        logic       req_type;
        logic [7:0] char_in;
    } t_req;

    typedef struct packed {
        logic [1:0] action;
        logic [5:0] line_length;
        logic       char_valid;
        logic [6:0] char_out;
        logic       last;
    } t_res;
endpackage

/* sv/lewh_if.sv */
interface lewh_req_if;
    import lewh_pkg::*;
    logic valid;
    logic ready;
    logic req_type;
    logic [7:0] char_in;
    modport source (output valid, req_type, char_in, input ready);
    modport sink (input valid, req_type, char_in, output ready);
endinterface

interface lewh_res_if;
    logic valid;
    logic ready;
    logic [1:0] action;
    logic [5:0] line_length;
    logic char_valid;
    logic [6:0] char_out;
    logic last;
    modport source (output valid, action, line_length, char_valid, char_out, last, input ready);
    modport sink (input valid, action, line_length, char_valid, char_out, last, output ready);
endinterface

/* sv/line_editor_with_history_top.sv */
// Channel   Dir  Payload
// i_req     in   req_type, char_in
// o_res     out  action, line_length, char_valid, char_out, last
// One item at a time. A plain edit emits a status item and, on redraw or ready, the line's characters.
// Recall copies n bytes at one byte a cycle through the ring memory;
// commit compares with the newest entry, then copies the line into the ring if it differs.
// Reset is synchronous and clears only control state; memories need no clearing.
// Output items leave through a single register; a stalled sink holds the walk.
module line_editor_with_history_top
    import lewh_pkg::*;
#(
    parameter int LINE_BYTES = LineBytesDef,
    parameter int HISTORY_ENTRIES = HistEntriesDef
) (
    input logic i_clk,
    input logic i_rst_n,
    lewh_req_if.sink i_req,
    lewh_res_if.source o_res
);
    localparam int LW = $clog2(LINE_BYTES);
    localparam int HW = (HISTORY_ENTRIES > 1) ? $clog2(HISTORY_ENTRIES) : 1;
    localparam int CW = LW + 1;
    localparam int FW = $clog2(HISTORY_ENTRIES + 1);
    localparam int AW = HW + LW;
    localparam int HE = HISTORY_ENTRIES;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_EMIT = 7'b0000010,
        S_COPY = 7'b0000100,
        S_CMPR = 7'b0001000,
        S_SAVE = 7'b0010000,
        S_LEN  = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    logic [6:0] line_mem [LINE_BYTES];
    logic [6:0] ring_mem [HE*(2**LW)];
    logic [CW-1:0] len_mem [HE];

    t_state r_st, n_st;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [1:0] r_esc, n_esc;
    logic r_brw, n_brw;
    logic [HW-1:0] r_bpos, n_bpos;
    logic [HW-1:0] r_wslot, n_wslot;
    logic [FW-1:0] r_fill, n_fill;
    logic [1:0] r_act, n_act;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_n, n_n;
    logic [HW-1:0] r_slot, n_slot;
    logic r_rd, n_rd;
    logic r_eq, n_eq;
    logic r_ov, n_ov;
    t_res r_res, n_res;

    // memory ports
    logic lw_en, rw_en, ln_en;
    logic [LW-1:0] lw_a, lr_a;
    logic [6:0] lw_d, rw_d, lr_q, rr_q;
    logic [AW-1:0] rw_a, rr_a;
    logic [CW-1:0] ln_q;

    always_ff @(posedge i_clk) begin
        if (lw_en) line_mem[lw_a] <= lw_d;
        lr_q <= line_mem[lr_a];
        if (rw_en) ring_mem[rw_a] <= rw_d;
        rr_q <= ring_mem[rr_a];
        if (ln_en) len_mem[r_wslot] <= r_cnt;
        ln_q <= len_mem[n_slot];
    end

    function automatic logic [HW-1:0] back(input logic [HW-1:0] ws, input logic [HW-1:0] d);
        logic [HW+1:0] t;
        t = {2'b0, ws} + (HW+2)'(HE) - (HW+2)'(1) - {2'b0, d};
        if (t >= (HW+2)'(HE)) t = t - (HW+2)'(HE);
        return t[HW-1:0];
    endfunction

    logic in_fire, busy_out;
    assign in_fire = i_req.valid && i_req.ready;
    assign busy_out = r_ov && !o_res.ready;
    assign i_req.ready = (r_st == S_IDLE) && !r_ov;
    assign o_res.valid = r_ov;
    assign o_res.action = r_res.action;
    assign o_res.line_length = r_res.line_length;
    assign o_res.char_valid = r_res.char_valid;
    assign o_res.char_out = r_res.char_out;
    assign o_res.last = r_res.last;

    logic [CW-1:0] lim;
    always_comb begin
        lim = (r_cnt > CW'(MaxResults - 1)) ? CW'(MaxResults - 1) : r_cnt;
    end

    always_comb begin
        logic [7:0] b;
        logic [HW:0] d;
        n_st = r_st; n_cnt = r_cnt; n_esc = r_esc; n_brw = r_brw; n_bpos = r_bpos;
        n_wslot = r_wslot; n_fill = r_fill; n_act = r_act; n_idx = r_idx; n_n = r_n;
        n_slot = r_slot; n_rd = 1'b0; n_eq = r_eq; n_res = r_res;
        n_ov = r_ov && !o_res.ready;
        lw_en = 1'b0; lw_a = r_idx[LW-1:0]; lw_d = rr_q;
        rw_en = 1'b0; rw_a = {r_wslot, r_idx[LW-1:0]} ; rw_d = lr_q;
        ln_en = 1'b0;
        lr_a = r_idx[LW-1:0]; rr_a = {r_slot, r_idx[LW-1:0]};
        b = i_req.char_in;
        d = '0;
        unique case (r_st)
            S_IDLE: begin
                if (in_fire) begin
                    n_act = ACT_NONE;
                    n_idx = '0;
                    n_st = S_EMIT;
                    if (i_req.req_type) begin
                        n_act = ACT_COMMIT;
                        n_brw = 1'b0;
                        n_eq = 1'b1;
                        if (r_cnt == '0) begin
                            n_st = S_EMIT;
                        end else if (r_fill != '0) begin
                            n_slot = back(r_wslot, '0);
                            n_st = S_LEN;
                        end else begin
                            n_eq = 1'b0;
                            n_st = S_SAVE;
                        end
                        if (r_cnt == '0) n_cnt = '0;
                    end else if (r_esc == 2'd1) begin
                        n_esc = (b == ChLbr) ? 2'd2 : 2'd0;
                    end else if (r_esc == 2'd2) begin
                        n_esc = 2'd0;
                        if (b == ChUp) begin
                            d = r_brw ? {1'b0, r_bpos} + 1'b1 : '0;
                            if (d < (HW+1)'(r_fill)) begin
                                n_bpos = d[HW-1:0]; n_brw = 1'b1;
                                n_slot = back(r_wslot, d[HW-1:0]);
                                n_act = ACT_REDRAW; n_st = S_LEN;
                            end
                        end else if (b == ChDn && r_brw) begin
                            n_act = ACT_REDRAW;
                            if (r_bpos == '0) begin
                                n_cnt = '0; n_brw = 1'b0;
                            end else begin
                                n_bpos = r_bpos - 1'b1;
                                n_slot = back(r_wslot, r_bpos - 1'b1);
                                n_st = S_LEN;
                            end
                        end
                    end else if (b == ChEsc) begin
                        n_esc = 2'd1;
                    end else if (b == ChCr || b == ChLf) begin
                        n_act = ACT_READY;
                    end else if (b == ChDel || b == ChBs || b == ChNak) begin
                        if (r_cnt != '0) begin
                            n_act = ACT_REDRAW;
                            n_cnt = (b == ChNak) ? '0 : r_cnt - 1'b1;
                        end
                    end else if (b >= ChSp && b < ChDel
                                 && r_cnt + 1'b1 < CW'(LINE_BYTES)) begin
                        lw_en = 1'b1; lw_a = r_cnt[LW-1:0]; lw_d = b[6:0];
                        n_cnt = r_cnt + 1'b1; n_act = ACT_REDRAW;
                    end
                end
            end
            S_LEN: begin
                // length read is registered; start byte walk
                n_n = (ln_q > CW'(LINE_BYTES - 1)) ? CW'(LINE_BYTES - 1) : ln_q;
                n_idx = '0; n_rd = 1'b0;
                if (r_act == ACT_COMMIT) begin
                    n_eq = (ln_q == r_cnt);
                    n_st = (ln_q == r_cnt) ? S_CMPR : S_SAVE;
                    n_idx = '0;
                end else begin
                    n_st = S_COPY;
                end
            end
            S_COPY: begin
                // issue read at r_idx, write previous read at r_idx-1
                if (r_rd) begin
                    lw_en = 1'b1; lw_a = LW'(r_idx - 1'b1); lw_d = rr_q;
                end
                if (r_idx < r_n) begin
                    rr_a = {r_slot, r_idx[LW-1:0]}; n_rd = 1'b1; n_idx = r_idx + 1'b1;
                end else begin
                    n_cnt = r_n; n_idx = '0; n_st = S_EMIT;
                end
            end
            S_CMPR: begin
                if (r_rd && (rr_q != lr_q)) n_eq = 1'b0;
                if (r_idx < r_cnt) begin
                    rr_a = {r_slot, r_idx[LW-1:0]}; lr_a = r_idx[LW-1:0];
                    n_rd = 1'b1; n_idx = r_idx + 1'b1;
                end else begin
                    n_idx = '0;
                    if (r_rd && (rr_q != lr_q)) n_st = S_SAVE;
                    else if (!r_eq) n_st = S_SAVE;
                    else begin n_cnt = '0; n_st = S_EMIT; end
                end
            end
            S_SAVE: begin
                if (r_rd) begin
                    rw_en = 1'b1; rw_a = {r_wslot, LW'(r_idx - 1'b1)}; rw_d = lr_q;
                end
                if (r_idx < r_cnt) begin
                    lr_a = r_idx[LW-1:0]; n_rd = 1'b1; n_idx = r_idx + 1'b1;
                end else begin
                    ln_en = 1'b1;
                    n_wslot = (r_wslot == HW'(HE - 1)) ? '0 : r_wslot + 1'b1;
                    if (r_fill < FW'(HE)) n_fill = r_fill + 1'b1;
                    n_cnt = '0; n_idx = '0; n_st = S_EMIT;
                end
            end
            S_EMIT: begin
                // status item, then start char walk on redraw or ready with a non-empty line
                if (!busy_out) begin
                    n_ov = 1'b1;
                    n_res = '{r_act, 6'(r_cnt), 1'b0, 7'd0, 1'b1};
                    if ((r_act == ACT_REDRAW || r_act == ACT_READY) && lim != '0) begin
                        n_res.last = 1'b0;
                        lr_a = '0; n_rd = 1'b1; n_idx = CW'(1); n_st = S_OUT;
                    end else begin
                        n_st = S_IDLE;
                    end
                end
            end
            S_OUT: begin
                n_rd = r_rd;
                if (!busy_out && r_rd) begin
                    n_ov = 1'b1;
                    n_res = '{r_act, 6'(r_cnt), 1'b1, lr_q, r_idx == lim};
                    if (r_idx == lim) begin
                        n_rd = 1'b0; n_st = S_IDLE;
                    end else begin
                        lr_a = r_idx[LW-1:0]; n_idx = r_idx + 1'b1;
                    end
                end else begin
                    lr_a = LW'(r_idx - 1'b1);
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_cnt <= '0; r_esc <= '0; r_brw <= 1'b0; r_bpos <= '0;
            r_wslot <= '0; r_fill <= '0; r_rd <= 1'b0; r_ov <= 1'b0; r_idx <= '0;
        end else begin
            r_st <= n_st; r_cnt <= n_cnt; r_esc <= n_esc; r_brw <= n_brw; r_bpos <= n_bpos;
            r_wslot <= n_wslot; r_fill <= n_fill; r_rd <= n_rd; r_ov <= n_ov; r_idx <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act <= n_act; r_n <= n_n; r_slot <= n_slot; r_eq <= n_eq; r_res <= n_res;
    end

    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt < CW'(LINE_BYTES)) else $error("line count overflow");
    a_fill_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(HE)) else $error("ring fill overflow");
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.ready) |=> o_res.valid) else $error("item lost");
    a_nointake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != S_IDLE) |-> !i_req.ready) else $error("accept while busy");
endmodule
